FILE: sv/dmcfu_pkg.sv
`timescale 1ns / 1ps

package dmcfu_pkg;

    localparam int ROW_W    = 27;
    localparam int NROWS    = 6;
    localparam int NFIELDS  = 8;
    localparam int FIELD_W  = 3;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 88;

    typedef logic [ROW_W-1:0] t_row;
    typedef logic [2:0]       t_idx;
    typedef logic [3:0]       t_glyph;

    localparam t_idx   LAST_IDX    = 3'd5;
    localparam t_idx   LAST_FONT   = 3'd4;
    localparam t_glyph GLYPH_COLON = 4'd10;

    typedef struct packed {
        t_glyph h_tens;
        t_glyph h_units;
        t_glyph m_tens;
        t_glyph m_units;
        t_glyph s_tens;
        t_glyph s_units;
    } t_digits;

    localparam logic [14:0] FONT [0:10] = '{
        15'o75557, 15'o11111, 15'o71747, 15'o71717, 15'o55711,
        15'o74717, 15'o74757, 15'o71111, 15'o75757, 15'o75717,
        15'o02020
    };

    localparam int FIELD_OFS [0:NFIELDS-1] = '{0, 4, 7, 10, 14, 17, 20, 24};

    function automatic logic [FIELD_W-1:0] glyph_row(input t_glyph g, input t_idx r);
        logic [14:0] f;
        logic [FIELD_W-1:0] bits;
        if (g > GLYPH_COLON) begin
            f = '0;
        end else begin
            f = FONT[g];
        end
        case (r)
            3'd0:    bits = f[14:12];
            3'd1:    bits = f[11:9];
            3'd2:    bits = f[8:6];
            3'd3:    bits = f[5:3];
            3'd4:    bits = f[2:0];
            default: bits = '0;
        endcase
        return bits;
    endfunction

    // Quotient by ten through the reciprocal 205/2048, exact for six-bit values.
    function automatic logic [2:0] tens_of(input logic [5:0] x);
        logic [13:0] p;
        p = 14'(x) * 14'd205;
        return p[13:11];
    endfunction

    function automatic t_glyph units_of(input logic [5:0] x);
        logic [5:0] t;
        t = 6'(tens_of(x)) * 6'd10;
        return t_glyph'(x - t);
    endfunction

    // Any differing bit of a digit or colon field marks the whole field.
    function automatic t_row expand_fields(input t_row d);
        t_row m;
        m = '0;
        for (int i = 0; i < NFIELDS; i++) begin
            if (|d[FIELD_OFS[i] +: FIELD_W]) begin
                m[FIELD_OFS[i] +: FIELD_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

FILE: sv/dmcfu_row_render.sv
`timescale 1ns / 1ps

module dmcfu_row_render
    import dmcfu_pkg::*;
(
    input  t_digits i_digits,
    input  t_idx    i_row,
    output t_row    o_row
);

    always_comb begin
        o_row = '0;
        if (i_row <= LAST_FONT) begin
            o_row[26:24] = glyph_row(i_digits.h_tens, i_row);
            o_row[22:20] = glyph_row(i_digits.h_units, i_row);
            o_row[19:17] = glyph_row(GLYPH_COLON, i_row);
            o_row[16:14] = glyph_row(i_digits.m_tens, i_row);
            o_row[12:10] = glyph_row(i_digits.m_units, i_row);
            o_row[9:7]   = glyph_row(GLYPH_COLON, i_row);
            o_row[6:4]   = glyph_row(i_digits.s_tens, i_row);
            o_row[2:0]   = glyph_row(i_digits.s_units, i_row);
        end
    end

endmodule

FILE: sv/dmcfu_row_merge.sv
`timescale 1ns / 1ps

module dmcfu_row_merge
    import dmcfu_pkg::*;
(
    input  t_row i_old,
    input  t_row i_src,
    input  t_row i_mask,
    input  logic i_apply,
    output t_row o_new,
    output t_row o_light,
    output t_row o_clear
);

    t_row w_diff;

    assign o_new   = i_apply ? ((i_old & ~i_mask) | (i_src & i_mask)) : i_old;
    assign w_diff  = o_new ^ i_old;
    assign o_light = w_diff & o_new;
    assign o_clear = w_diff & i_old;

endmodule

FILE: sv/dot_matrix_clock_frame_updater.sv
`timescale 1ns / 1ps

// Each accepted request carries one time tick (hours in bits 4:0, minutes in
// bits 10:5, seconds in bits 16:11) and produces 36 row results: six animation
// steps of rows 0 to 5, the final one flagged by tlast. The block renders the
// target bitmap one row a cycle, building the change mask, and then updates
// one row a cycle, while the output slot is free, through a single merge unit
// while the six stored rows rotate past it. The input is therefore not ready
// from an accepted request until the final row result has been registered,
// and a waiting result that holds up the row updates keeps it not ready too,
// so no new request is taken before a tick is done. The scroll mode register
// selects rolling or in-place replacement and should be written only while the
// block is idle. The displayed bitmap always equals the working bitmap between
// ticks, so one set of row registers holds both.
module dot_matrix_clock_frame_updater
    import dmcfu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // hours [4:0], minutes [10:5], seconds [16:11], zero [23:17]
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // step [2:0], row [5:3], row_bits [32:6], light_bits [59:33],
    // clear_bits [86:60], zero [87]
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RENDER,
        S_STEP
    } t_state;

    t_state  r_state;
    logic    r_scroll;
    t_digits r_digits;
    t_digits n_digits;
    t_idx    r_row;
    t_idx    r_step;
    t_row    r_mask;
    t_row    r_target [0:NROWS-1];
    t_row    r_work   [0:NROWS-1];

    logic    r_out_valid;
    logic    r_out_last;
    t_idx    r_out_step;
    t_idx    r_out_row;
    t_row    r_out_bits;
    t_row    r_out_light;
    t_row    r_out_clear;

    t_row    w_render;
    t_row    w_src;
    logic    w_apply;
    t_row    w_new;
    t_row    w_light;
    t_row    w_clear;
    logic    w_accept;
    logic    w_slot_free;
    logic    w_last_row;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_last_row  = (r_row == LAST_IDX);

    always_comb begin
        n_digits.h_tens  = t_glyph'(tens_of({1'b0, i_s_axis_tdata[4:0]}));
        n_digits.h_units = units_of({1'b0, i_s_axis_tdata[4:0]});
        n_digits.m_tens  = t_glyph'(tens_of(i_s_axis_tdata[10:5]));
        n_digits.m_units = units_of(i_s_axis_tdata[10:5]);
        n_digits.s_tens  = t_glyph'(tens_of(i_s_axis_tdata[16:11]));
        n_digits.s_units = units_of(i_s_axis_tdata[16:11]);
    end

    dmcfu_row_render u_render (
        .i_digits (r_digits),
        .i_row    (r_row),
        .o_row    (w_render)
    );

    // Rows pass the merge unit in order; slot 1 still holds the old row below.
    always_comb begin
        if (r_scroll && !w_last_row) begin
            w_src = r_work[1];
        end else begin
            w_src = r_target[r_step];
        end
        w_apply = r_scroll || (r_row == r_step);
    end

    dmcfu_row_merge u_merge (
        .i_old   (r_work[0]),
        .i_src   (w_src),
        .i_mask  (r_mask),
        .i_apply (w_apply),
        .o_new   (w_new),
        .o_light (w_light),
        .o_clear (w_clear)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {1'b0, r_out_clear, r_out_light, r_out_bits,
                              r_out_row, r_out_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scroll    <= 1'b0;
            r_row       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            for (int i = 0; i < NROWS; i++) begin
                r_work[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_scroll <= i_cfg_wdata;
            end
            r_out_valid <= ((r_state == S_STEP) && w_slot_free)
                           || (r_out_valid && !i_m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_digits <= n_digits;
                        r_mask   <= '0;
                        r_row    <= '0;
                        r_step   <= '0;
                        r_state  <= S_RENDER;
                    end
                end
                S_RENDER: begin
                    r_target[r_row] <= w_render;
                    if (r_row <= LAST_FONT) begin
                        r_mask <= r_mask | expand_fields(w_render ^ r_work[0]);
                    end
                    for (int i = 0; i < NROWS - 1; i++) begin
                        r_work[i] <= r_work[i+1];
                    end
                    r_work[NROWS-1] <= r_work[0];
                    if (w_last_row) begin
                        r_row   <= '0;
                        r_state <= S_STEP;
                    end else begin
                        r_row <= r_row + 3'd1;
                    end
                end
                S_STEP: begin
                    if (w_slot_free) begin
                        r_out_last  <= w_last_row && (r_step == LAST_IDX);
                        r_out_step  <= r_step;
                        r_out_row   <= r_row;
                        r_out_bits  <= w_new;
                        r_out_light <= w_light;
                        r_out_clear <= w_clear;
                        for (int i = 0; i < NROWS - 1; i++) begin
                            r_work[i] <= r_work[i+1];
                        end
                        r_work[NROWS-1] <= w_new;
                        if (w_last_row) begin
                            r_row <= '0;
                            if (r_step == LAST_IDX) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_step <= r_step + 3'd1;
                            end
                        end else begin
                            r_row <= r_row + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_row <= LAST_IDX && r_step <= LAST_IDX))
        else $error("row or step counter out of range");

    a_accept_starts_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RENDER && r_row == '0))
        else $error("accepted tick did not start rendering at row zero");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_step == LAST_IDX && r_out_row == LAST_IDX))
        else $error("last flag on a result other than the final row");

    a_light_clear_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_light & r_out_clear) == '0
                         && (r_out_light & ~r_out_bits) == '0
                         && (r_out_clear & r_out_bits) == '0))
        else $error("light and clear bits inconsistent with the row");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && w_slot_free && w_last_row && r_step == LAST_IDX)
            |=> (r_state == S_IDLE && r_out_last))
        else $error("sequencer did not return to idle after the final row");

endmodule
